FILE: design/lrhp_pkg.sv
// ----------------------------------------------------------------------------
// lrhp_pkg
// Shared types and constants for the hybrid LFSR / rule-90 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lrhp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned TAP_HI = 31;
  localparam int unsigned TAP_MID = 21;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic load;
    logic shift;
    logic gen;
  } lrhp_ctrl_t;

endpackage

`default_nettype wire

FILE: design/lfsr_rule90_hybrid_prng.sv
// ----------------------------------------------------------------------------
// lfsr_rule90_hybrid_prng
// Pseudo-random word generator: 32-bit LFSR XOR a 32-cell periodic rule-90
// automaton, built as a row of bit-slice cells.
// ----------------------------------------------------------------------------
// A reseed beat (opcode 0) loads the LFSR with the seed, the automaton with
// the seed bit-reversed and the step count with the seed's low six bits; it
// gives no result and leaves the block idle for the next beat. A draw beat
// (opcode 1) shifts the LFSR once, then runs the automaton one generation per
// cycle for the current step count, and the block takes no new beat until it
// is done. The result sits in an output register, so the next beat can be
// taken while it waits; a later draw holds at its end until the register is
// free. Result low six bits become the next step count.
`default_nettype none

module lfsr_rule90_hybrid_prng (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word
);

  localparam int unsigned W  = lrhp_pkg::WORD_W;
  localparam int unsigned SW = lrhp_pkg::STEP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_word_r, out_word_nxt;

  lrhp_pkg::lrhp_ctrl_t ctrl;
  logic [W-1:0] lfsr_q;
  logic [W-1:0] ca_q;
  logic [W-1:0] lfsr_in;
  logic         fb;
  logic         in_acc;
  logic         finish;
  logic [W-1:0] word;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fb       = ~(lfsr_q[lrhp_pkg::TAP_HI] ^ lfsr_q[lrhp_pkg::TAP_MID]
                      ^ lfsr_q[1] ^ lfsr_q[0]);
  assign word     = lfsr_q ^ ca_q;
  assign finish   = (state_r == ST_RUN) && (cnt_r == '0)
                    && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.load  = in_acc && (in_opcode == lrhp_pkg::OP_RESEED);
    ctrl.shift = in_acc && (in_opcode == lrhp_pkg::OP_DRAW);
    ctrl.gen   = (state_r == ST_RUN) && (cnt_r != '0);
  end

  always_comb begin
    lfsr_in[0] = fb;
    for (int i = 1; i < W; i++) begin
      lfsr_in[i] = lfsr_q[i-1];
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_cell
    lrhp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .seed_lfsr (in_seed_value[g]),
      .seed_ca   (in_seed_value[W-1-g]),
      .lfsr_in   (lfsr_in[g]),
      .ca_left   (ca_q[(g + W - 1) % W]),
      .ca_right  (ca_q[(g + 1) % W]),
      .lfsr_q    (lfsr_q[g]),
      .ca_q      (ca_q[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.load) begin
          step_nxt = in_seed_value[SW-1:0];
        end else if (ctrl.shift) begin
          cnt_nxt   = step_r;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ctrl.gen) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (finish) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word;
          step_nxt      = word[SW-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

`default_nettype wire

FILE: design/lrhp_cell.sv
// ----------------------------------------------------------------------------
// lrhp_cell
// One slice of the generator: one LFSR bit and one rule-90 automaton cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhp_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrhp_pkg::lrhp_ctrl_t ctrl,
  input  wire logic              seed_lfsr,
  input  wire logic              seed_ca,
  input  wire logic              lfsr_in,
  input  wire logic              ca_left,
  input  wire logic              ca_right,
  output logic                   lfsr_q,
  output logic                   ca_q
);

  logic lfsr_r, lfsr_nxt;
  logic ca_r, ca_nxt;

  always_comb begin
    lfsr_nxt = lfsr_r;
    ca_nxt   = ca_r;
    if (ctrl.load) begin
      lfsr_nxt = seed_lfsr;
      ca_nxt   = seed_ca;
    end else begin
      if (ctrl.shift) begin
        lfsr_nxt = lfsr_in;
      end
      if (ctrl.gen) begin
        ca_nxt = ca_left ^ ca_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 1'b0;
      ca_r   <= 1'b0;
    end else begin
      lfsr_r <= lfsr_nxt;
      ca_r   <= ca_nxt;
    end
  end

  assign lfsr_q = lfsr_r;
  assign ca_q   = ca_r;

endmodule

`default_nettype wire

FILE: design/lrhp_chk.sv
// ----------------------------------------------------------------------------
// lrhp_chk
// Port-level checks for the hybrid generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == lrhp_pkg::OP_RESEED) && !out_valid
    |=> !out_valid)
    else $error("reseed produced a result");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == lrhp_pkg::OP_DRAW) |=> !in_ready)
    else $error("draw did not occupy the block");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a draw in progress");

endmodule

bind lfsr_rule90_hybrid_prng lrhp_chk u_lrhp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_random_word (out_random_word)
);

`default_nettype wire

FILE: dv/lrhp_checker.sv
// ----------------------------------------------------------------------------
// lrhp_checker
// Watches both channels of the hybrid LFSR / rule-90 generator, keeps its own
// copy of the LFSR, the automaton row and the step count, predicts each drawn
// word and compares it with the words coming out, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_seed_value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_random_word,
  output int               fail_count,
  output int               words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [lrhp_pkg::WORD_W-1:0] lfsr_q;
  logic [lrhp_pkg::WORD_W-1:0] row_q;
  logic [lrhp_pkg::STEP_W-1:0] steps_q;
  logic [lrhp_pkg::WORD_W-1:0] expected_words[$];
  logic [lrhp_pkg::WORD_W-1:0] want;

  function automatic logic [lrhp_pkg::WORD_W-1:0] rule90_step(
    input logic [lrhp_pkg::WORD_W-1:0] row
  );
    return {row[lrhp_pkg::WORD_W-2:0], row[lrhp_pkg::WORD_W-1]}
           ^ {row[0], row[lrhp_pkg::WORD_W-1:1]};
  endfunction

  function automatic logic [lrhp_pkg::WORD_W-1:0] reverse_bits(
    input logic [lrhp_pkg::WORD_W-1:0] v
  );
    logic [lrhp_pkg::WORD_W-1:0] r;
    for (int i = 0; i < lrhp_pkg::WORD_W; i++) r[i] = v[lrhp_pkg::WORD_W-1-i];
    return r;
  endfunction

  task automatic load_seed(input logic [lrhp_pkg::WORD_W-1:0] seed);
    lfsr_q  = seed;
    row_q   = reverse_bits(seed);
    steps_q = seed[lrhp_pkg::STEP_W-1:0];
  endtask

  task automatic draw_next_word();
    logic                        fb;
    logic [lrhp_pkg::WORD_W-1:0] word;
    fb     = lfsr_q[lrhp_pkg::TAP_HI] ^ lfsr_q[lrhp_pkg::TAP_MID] ^ lfsr_q[1] ^ lfsr_q[0];
    lfsr_q = {lfsr_q[lrhp_pkg::WORD_W-2:0], ~fb};
    for (int n = 0; n < int'(steps_q); n++) row_q = rule90_step(row_q);
    word    = lfsr_q ^ row_q;
    steps_q = word[lrhp_pkg::STEP_W-1:0];
    expected_words.push_back(word);
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
    lfsr_q        = '0;
    row_q         = '0;
    steps_q       = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lfsr_q  = '0;
      row_q   = '0;
      steps_q = '0;
      expected_words.delete();
    end else begin
      // output side first: a word leaving now can only come from an earlier beat
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("random_word: no word expected, got %h", out_random_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want) begin
            $error("random_word: expected %h, got %h", want, out_random_word);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == lrhp_pkg::OP_RESEED) load_seed(in_seed_value);
        else draw_next_word();
      end
    end
    words_pending = expected_words.size();
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the hybrid LFSR / rule-90 generator: directed
// reseeds and draws, then a long random mix dominated by draws, with random
// stalls on both channels; prediction and comparison sit in lrhp_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1500;
  localparam int CALM_BEATS   = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [31:0] in_seed_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_word;
  logic        calm;
  int          fail_count;
  int          words_pending;

  lfsr_rule90_hybrid_prng u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

  lrhp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_beat(input logic op, input logic [31:0] seed);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom() & 32'hFFFF_FFC0;
      3:       return $urandom() | 32'h0000_003F;
      default: return $urandom();
    endcase
  endfunction

  // result side stalls
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= lrhp_pkg::OP_DRAW;
    in_seed_value <= '0;
    calm          <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // draws straight from reset, zero step count
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_DRAW, 32'hFFFF_FFFF);
    send_beat(lrhp_pkg::OP_RESEED, 32'h0);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    // full 63-step draw
    send_beat(lrhp_pkg::OP_RESEED, 32'hFFFF_FFFF);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_RESEED, 32'h8000_0000);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_RESEED, 32'h0000_0001);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_RESEED, 32'hAAAA_AAAA);
    send_beat(lrhp_pkg::OP_DRAW, 32'h5555_5555);
    send_beat(lrhp_pkg::OP_RESEED, 32'h5555_5540);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    send_beat(lrhp_pkg::OP_RESEED, 32'h0000_003F);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);
    // back-to-back reseeds, only the last counts
    send_beat(lrhp_pkg::OP_RESEED, 32'h1234_5678);
    send_beat(lrhp_pkg::OP_RESEED, 32'hDEAD_BEEF);
    send_beat(lrhp_pkg::OP_DRAW, 32'h0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - CALM_BEATS) calm <= 1'b1;
      if ($urandom_range(0, 9) < 2) send_beat(lrhp_pkg::OP_RESEED, pick_seed());
      else send_beat(lrhp_pkg::OP_DRAW, $urandom());
    end
    in_valid <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("** lfsr_rule90_hybrid_prng: PASSED **");
    end else begin
      $display("** lfsr_rule90_hybrid_prng: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** lfsr_rule90_hybrid_prng: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
